// File: sv/tsm_pkg.sv
// Package for the timestamp ordered source merge.
// Holds sizes, item kind codes, state encoding and shared structs; no dependencies.
package tsm_pkg;
    localparam int NUM_SOURCES = 16;
    localparam int QUEUE_DEPTH = 64;
    localparam int SRC_W = $clog2(NUM_SOURCES);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W = SRC_W + PTR_W;
    localparam int SLOTS = NUM_SOURCES * QUEUE_DEPTH;
    localparam int MSG_W = 64 + 64 + 64 + 4;
    localparam logic [4:0] NO_SOURCE = 5'd16;

    // Configuration register indexes.
    localparam logic [0:0] REG_SELF_INDEX = 1'b0;
    localparam logic [0:0] REG_SOURCE_COUNT = 1'b1;

    typedef enum logic [1:0] {
        K_PUSH  = 2'd0,
        K_BOUND = 2'd1,
        K_POP_E = 2'd2,
        K_POP_S = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DONE,
        S_SCAN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  source;
        logic [63:0] time_value;
        logic [3:0]  message_kind;
        logic [63:0] line_address;
        logic [63:0] message_id;
    } t_req;

    typedef struct packed {
        logic        popped;
        logic [3:0]  pop_source;
        logic [63:0] pop_time;
        logic [3:0]  pop_kind;
        logic [63:0] pop_line_address;
        logic [63:0] pop_message_id;
        logic [63:0] safe_horizon;
        logic [63:0] earliest_time;
        logic [4:0]  earliest_source;
        logic        dropped;
    } t_rsp;
endpackage

// File: sv/tsm_if.sv
// Valid/ready channel carrying one payload of type T.
// No dependencies; the payload type is a parameter.
interface tsm_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/tsm_ram.sv
// Generic single-port write, single-port read RAM with a registered read.
// No dependencies.
module tsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/tsm_scan.sv
// Sequential scan over per-source head times and bounds: earliest head and safe time.
// Depends on tsm_pkg.
module tsm_scan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tsm_pkg::NUM_SOURCES-1:0] i_part,
    input  logic [tsm_pkg::NUM_SOURCES-1:0] i_nonempty,
    input  logic [63:0]                  i_head_time [tsm_pkg::NUM_SOURCES],
    input  logic [63:0]                  i_bound [tsm_pkg::NUM_SOURCES],
    output logic                         o_done,
    output logic [63:0]                  o_safe,
    output logic [63:0]                  o_etime,
    output logic [4:0]                   o_esrc
);
    localparam int IW = tsm_pkg::SRC_W + 1;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_busy, n_busy;
    logic [63:0]   r_safe, n_safe, r_et, n_et;
    logic [4:0]    r_es, n_es;
    logic          r_found, n_found;
    logic [tsm_pkg::SRC_W-1:0] w_s;
    logic [63:0]   w_m;

    assign w_s = r_idx[tsm_pkg::SRC_W-1:0];

    always_comb begin
        n_idx = r_idx;
        n_busy = r_busy;
        n_safe = r_safe;
        n_et = r_et;
        n_es = r_es;
        n_found = r_found;
        w_m = i_bound[w_s];
        if (i_start) begin
            n_idx = '0;
            n_busy = 1'b1;
            n_safe = '1;
            n_et = '1;
            n_es = tsm_pkg::NO_SOURCE;
            n_found = 1'b0;
        end else if (r_busy) begin
            if (i_part[w_s]) begin
                if (i_nonempty[w_s] && i_head_time[w_s] < w_m) begin
                    w_m = i_head_time[w_s];
                end
                if (w_m < r_safe) begin
                    n_safe = w_m;
                end
                if (i_nonempty[w_s] && (!r_found || i_head_time[w_s] < r_et)) begin
                    n_et = i_head_time[w_s];
                    n_es = 5'(w_s);
                    n_found = 1'b1;
                end
            end
            n_idx = r_idx + 1'b1;
            if (r_idx == IW'(tsm_pkg::NUM_SOURCES - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx <= '0;
        end else begin
            r_busy <= n_busy;
            r_idx <= n_idx;
        end
        r_safe <= n_safe;
        r_et <= n_et;
        r_es <= n_es;
        r_found <= n_found;
    end

    assign o_done = r_busy && r_idx == IW'(tsm_pkg::NUM_SOURCES - 1);
    assign o_safe = n_safe;
    assign o_etime = n_et;
    assign o_esrc = n_es;
endmodule

// File: sv/timestamp_ordered_source_merge.sv
// Top level of the timestamp ordered source merge inbox.
// Depends on tsm_pkg, tsm_if, tsm_ram and tsm_scan.
//
// One request is handled at a time. Message payloads live in one RAM of
// NUM_SOURCES * QUEUE_DEPTH slots; head pointers, fill counts, lower bounds
// and a copy of each queue's head timestamp are kept in registers. After the
// accepting edge a push, bound or refused pop passes READ and DONE before
// the summary scan; a pop that succeeds passes READ, OUT and DONE, since it
// reads the head slot and then, after advancing the head pointer, reads the
// new head time. The scan walks all NUM_SOURCES sources one per cycle and
// starts over on a configuration write. The result is held in an output
// register until taken, and the next request is accepted at the earliest in
// the cycle after that, so no request is accepted before the last result has
// been taken; the scan sets the rate. A configuration write starts a scan of
// its own, without a result, so that the earliest head used by the next pop
// reflects the new settings; requests wait behind it. No clearing pass is
// needed after reset.
module timestamp_ordered_source_merge (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    tsm_if.sink         in_req,
    tsm_if.source       out_rsp
);
    localparam int NS = tsm_pkg::NUM_SOURCES;
    localparam int SW = tsm_pkg::SRC_W;
    localparam int PW = tsm_pkg::PTR_W;
    localparam int CW = tsm_pkg::CNT_W;
    localparam int AW = tsm_pkg::SLOT_W;

    tsm_pkg::t_state r_state, n_state;
    tsm_pkg::t_req   r_req;
    tsm_pkg::t_rsp   r_rsp;
    logic [3:0]  r_self;
    logic [4:0]  r_count;
    logic [PW-1:0] r_head [NS];
    logic [CW-1:0] r_fill [NS];
    logic [63:0]   r_bound [NS];
    logic [63:0]   r_htime [NS];
    logic [SW-1:0] r_tgt;
    logic          r_pop;
    logic          r_ofull;
    logic [4:0]    r_es;
    logic          r_cfg_scan;

    logic [NS-1:0] w_part, w_nonempty;
    logic          w_take, w_start, w_sdone, w_fin;
    logic [63:0]   w_safe, w_et;
    logic [4:0]    w_es, w_active, w_es_scan;
    logic [SW-1:0] w_src, w_psrc;
    logic          w_pop_ok, w_push_ok;
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [tsm_pkg::MSG_W-1:0] w_wdata, w_rdata;
    logic [PW:0]   w_pos;

    assign w_active = (r_count > 5'(NS)) ? 5'(NS) : r_count;
    always_comb begin
        for (int s = 0; s < NS; s++) begin
            w_part[s] = (5'(s) < w_active) && (4'(s) != r_self);
            w_nonempty[s] = r_fill[s] != '0;
        end
    end

    assign w_take = in_req.valid && in_req.ready;
    assign in_req.ready = (r_state == tsm_pkg::S_IDLE) && !r_ofull;
    assign w_src = in_req.data.source[SW-1:0];
    assign w_push_ok = w_part[w_src] && r_fill[w_src] < CW'(tsm_pkg::QUEUE_DEPTH);
    assign w_pos = {1'b0, r_head[w_src]} + (PW+1)'(r_fill[w_src]);

    // Pop target: earliest head from the last scan, or the named source.
    always_comb begin
        w_psrc = (in_req.data.kind == tsm_pkg::K_POP_E) ? w_es[SW-1:0] : w_src;
        w_pop_ok = w_part[w_psrc] && w_nonempty[w_psrc]
                 && r_htime[w_psrc] <= in_req.data.time_value;
        if (in_req.data.kind == tsm_pkg::K_POP_E && w_es == tsm_pkg::NO_SOURCE) begin
            w_pop_ok = 1'b0;
        end
    end
    // Earliest head as found by the most recent scan, which always follows
    // the last change of queues or configuration.
    assign w_es = r_es;

    // Memory write on push, read at the head slot (pop) or new head (after pop).
    assign w_we = w_take && in_req.data.kind == tsm_pkg::K_PUSH && w_push_ok;
    assign w_waddr = {w_src, w_pos[PW-1:0] - ((w_pos >= (PW+1)'(tsm_pkg::QUEUE_DEPTH))
                      ? PW'(tsm_pkg::QUEUE_DEPTH) : PW'(0))};
    assign w_wdata = {in_req.data.time_value, in_req.data.line_address,
                      in_req.data.message_id, in_req.data.message_kind};
    assign w_raddr = (r_state == tsm_pkg::S_IDLE) ? {w_psrc, r_head[w_psrc]}
                                                  : {r_tgt, r_head[r_tgt]};

    tsm_ram #(.WIDTH(tsm_pkg::MSG_W), .DEPTH(tsm_pkg::SLOTS)) u_msg (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    assign w_start = r_state == tsm_pkg::S_DONE;
    tsm_scan u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_part(w_part),
        .i_nonempty(w_nonempty), .i_head_time(r_htime), .i_bound(r_bound),
        .o_done(w_sdone), .o_safe(w_safe), .o_etime(w_et), .o_esrc(w_es_scan)
    );

    // A scan finishes unless a configuration write restarts it.
    assign w_fin = (r_state == tsm_pkg::S_SCAN) && w_sdone && !i_cfg_we;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tsm_pkg::S_IDLE: begin
                if (w_take) n_state = tsm_pkg::S_READ;
                else if (i_cfg_we) n_state = tsm_pkg::S_DONE;
            end
            tsm_pkg::S_READ: n_state = r_pop ? tsm_pkg::S_OUT : tsm_pkg::S_DONE;
            tsm_pkg::S_OUT:  n_state = tsm_pkg::S_DONE;
            tsm_pkg::S_DONE: n_state = tsm_pkg::S_SCAN;
            tsm_pkg::S_SCAN: begin
                if (i_cfg_we) n_state = tsm_pkg::S_DONE;
                else if (w_sdone) n_state = tsm_pkg::S_IDLE;
            end
            default:         n_state = tsm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsm_pkg::S_IDLE;
            r_self <= '0;
            r_count <= 5'd16;
            r_ofull <= 1'b0;
            r_pop <= 1'b0;
            r_tgt <= '0;
            r_es <= tsm_pkg::NO_SOURCE;
            r_cfg_scan <= 1'b0;
            r_rsp.earliest_source <= tsm_pkg::NO_SOURCE;
            for (int s = 0; s < NS; s++) begin
                r_head[s] <= '0;
                r_fill[s] <= '0;
                r_bound[s] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == tsm_pkg::REG_SELF_INDEX) r_self <= i_cfg_data[3:0];
                else r_count <= i_cfg_data;
            end
            // A scan started by a configuration write gives no result.
            if (r_state == tsm_pkg::S_IDLE && i_cfg_we && !w_take) r_cfg_scan <= 1'b1;
            if (out_rsp.valid && out_rsp.ready) r_ofull <= 1'b0;
            if (w_take) begin
                r_cfg_scan <= 1'b0;
                r_pop <= 1'b0;
                r_rsp.dropped <= 1'b0;
                r_rsp.popped <= 1'b0;
                r_rsp.pop_source <= '0;
                r_rsp.pop_time <= '0;
                r_rsp.pop_kind <= '0;
                r_rsp.pop_line_address <= '0;
                r_rsp.pop_message_id <= '0;
                unique case (tsm_pkg::t_kind'(in_req.data.kind))
                    tsm_pkg::K_PUSH: begin
                        if (w_push_ok) begin
                            r_fill[w_src] <= r_fill[w_src] + 1'b1;
                            if (r_fill[w_src] == '0) r_htime[w_src] <= in_req.data.time_value;
                        end else begin
                            r_rsp.dropped <= 1'b1;
                        end
                    end
                    tsm_pkg::K_BOUND: r_bound[w_src] <= in_req.data.time_value;
                    tsm_pkg::K_POP_E, tsm_pkg::K_POP_S: begin
                        if (w_pop_ok) begin
                            r_pop <= 1'b1;
                            r_tgt <= w_psrc;
                            r_fill[w_psrc] <= r_fill[w_psrc] - 1'b1;
                            r_head[w_psrc] <= (r_head[w_psrc] == PW'(tsm_pkg::QUEUE_DEPTH - 1))
                                            ? '0 : r_head[w_psrc] + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (r_state == tsm_pkg::S_READ && r_pop) begin
                r_rsp.popped <= 1'b1;
                r_rsp.pop_source <= 4'(r_tgt);
                {r_rsp.pop_time, r_rsp.pop_line_address, r_rsp.pop_message_id,
                 r_rsp.pop_kind} <= w_rdata;
            end
            // New head time of the popped queue, read after the pointer moved.
            if (r_state == tsm_pkg::S_OUT) r_htime[r_tgt] <= w_rdata[tsm_pkg::MSG_W-1 -: 64];
            if (w_fin) begin
                r_es <= w_es_scan;
                if (!r_cfg_scan) begin
                    r_rsp.safe_horizon <= w_safe;
                    r_rsp.earliest_time <= w_et;
                    r_rsp.earliest_source <= w_es_scan;
                    r_ofull <= 1'b1;
                end
            end
        end
    end

    assign out_rsp.valid = r_ofull;
    assign out_rsp.data = r_rsp;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != tsm_pkg::S_IDLE) |-> !in_req.ready) else $error("accept while busy");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill[r_tgt] <= CW'(tsm_pkg::QUEUE_DEPTH)) else $error("fill overflow");
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_rsp.valid && !out_rsp.ready) |=> $stable(r_rsp)) else $error("result changed");
`endif
endmodule

// File: dv/tsm_checker.sv
`timescale 1ns / 100ps
// Checker for the timestamp ordered source merge: watches both channels,
// predicts each result from its own model of the inbox and compares them.
// Depends on tsm_pkg.
module tsm_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_index,
    input  logic [4:0]    i_cfg_data,
    input  logic          i_req_valid,
    input  logic          i_req_ready,
    input  tsm_pkg::t_req i_req,
    input  logic          i_rsp_valid,
    input  logic          i_rsp_ready,
    input  tsm_pkg::t_rsp i_rsp,
    output int            o_fail_count,
    output int            o_pending
);
    localparam logic [63:0] ALL_ONES = '1;
    localparam int NS = tsm_pkg::NUM_SOURCES;

    // Each queue is modeled as a SystemVerilog queue of requests.
    tsm_pkg::t_req inbox_q [NS][$];
    logic [63:0]   bounds [NS];
    logic [3:0]    own_src;
    logic [4:0]    src_count;
    tsm_pkg::t_rsp expected_rsps [$];

    function automatic int in_use();
        return (src_count > NS) ? NS : int'(src_count);
    endfunction

    function automatic bit takes_part(int s);
        return s < in_use() && s != int'(own_src);
    endfunction

    function automatic int earliest_src();
        int best;
        best = NS;
        for (int s = 0; s < NS; s++)
            if (takes_part(s) && inbox_q[s].size() != 0)
                if (best == NS ||
                    inbox_q[s][0].time_value < inbox_q[best][0].time_value)
                    best = s;
        return best;
    endfunction

    function automatic void try_pop(int s, logic [63:0] limit, inout tsm_pkg::t_rsp r);
        tsm_pkg::t_req m;
        if (!takes_part(s) || inbox_q[s].size() == 0) return;
        if (inbox_q[s][0].time_value > limit) return;
        m = inbox_q[s][0];
        inbox_q[s].delete(0);
        r.popped = 1'b1;
        r.pop_source = s[3:0];
        r.pop_time = m.time_value;
        r.pop_kind = m.message_kind;
        r.pop_line_address = m.line_address;
        r.pop_message_id = m.message_id;
    endfunction

    function automatic tsm_pkg::t_rsp merge_request(tsm_pkg::t_req q);
        tsm_pkg::t_rsp r;
        int s;
        int e;
        logic [63:0] m;
        r = '0;
        s = int'(q.source);
        case (tsm_pkg::t_kind'(q.kind))
            tsm_pkg::K_PUSH: begin
                if (!takes_part(s) || inbox_q[s].size() >= tsm_pkg::QUEUE_DEPTH)
                    r.dropped = 1'b1;
                else
                    inbox_q[s].insert(inbox_q[s].size(), q);
            end
            tsm_pkg::K_BOUND: bounds[s] = q.time_value;
            tsm_pkg::K_POP_E: begin
                e = earliest_src();
                if (e != NS) try_pop(e, q.time_value, r);
            end
            default: try_pop(s, q.time_value, r);
        endcase
        // Summary fields reflect the state after this request.
        r.safe_horizon = ALL_ONES;
        for (int k = 0; k < NS; k++) begin
            if (!takes_part(k)) continue;
            m = bounds[k];
            if (inbox_q[k].size() != 0 && inbox_q[k][0].time_value < m)
                m = inbox_q[k][0].time_value;
            if (m < r.safe_horizon) r.safe_horizon = m;
        end
        e = earliest_src();
        r.earliest_source = e[4:0];
        r.earliest_time = (e == NS) ? ALL_ONES : inbox_q[e][0].time_value;
        return r;
    endfunction

    always @(posedge i_clk) begin
        tsm_pkg::t_rsp exp_rsp;
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                inbox_q[s].delete();
                bounds[s] = '0;
            end
            own_src = '0;
            src_count = 5'd16;
            expected_rsps.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == tsm_pkg::REG_SELF_INDEX) own_src = i_cfg_data[3:0];
                else src_count = i_cfg_data;
            end
            if (i_rsp_valid && i_rsp_ready) begin
                if (expected_rsps.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected response %p", i_rsp);
                end else begin
                    exp_rsp = expected_rsps[0];
                    expected_rsps.delete(0);
                    if (i_rsp !== exp_rsp) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected %p actual %p", exp_rsp, i_rsp);
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                expected_rsps.insert(expected_rsps.size(), merge_request(i_req));
        end
        o_pending = expected_rsps.size();
    end
endmodule

// File: dv/timestamp_ordered_source_merge_tb.sv
`timescale 1ns / 100ps
// Testbench top for the timestamp ordered source merge: drives requests,
// configuration and response stalls, and reports the verdict from tsm_checker.
// Depends on tsm_pkg, tsm_if, tsm_checker and the block itself.
module timestamp_ordered_source_merge_tb;
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [0:0] cfg_index = '0;
    logic [4:0] cfg_data = '0;
    int         fail_count;
    int         pending;

    tsm_if #(.T(tsm_pkg::t_req)) req_ch ();
    tsm_if #(.T(tsm_pkg::t_rsp)) rsp_ch ();

    localparam int LATENCY = tsm_pkg::NUM_SOURCES + 8;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    timestamp_ordered_source_merge DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .in_req     (req_ch.sink),
        .out_rsp    (rsp_ch.source)
    );

    tsm_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req_valid (req_ch.valid),
        .i_req_ready (req_ch.ready),
        .i_req       (req_ch.data),
        .i_rsp_valid (rsp_ch.valid),
        .i_rsp_ready (rsp_ch.ready),
        .i_rsp       (rsp_ch.data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Times are drawn from a small window most of the time so that heads
    // compare against bounds and limits in both directions; the rest hits
    // the extremes of the 64-bit range or any value in it.
    function automatic logic [63:0] rand_time();
        case ($urandom_range(0, 9))
            0: return '1;
            1: return '0;
            2: return {$urandom, $urandom};
            default: return 64'(1000 + $urandom_range(0, 40));
        endcase
    endfunction

    // Sends one request and waits until ready is high after an edge; the
    // gap before the request is random so that it falls on every phase of
    // the block. With no gap, valid stays high from the previous request.
    task automatic send_request(tsm_pkg::t_kind kind, logic [3:0] src, logic [63:0] tv);
        tsm_pkg::t_req q;
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        q.kind = kind;
        q.source = src;
        q.time_value = tv;
        q.message_kind = 4'($urandom);
        q.line_address = {$urandom, $urandom};
        q.message_id = {$urandom, $urandom};
        req_ch.valid <= 1'b1;
        req_ch.data <= q;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // Drops valid after the last request of a run.
    task automatic release_request();
        req_ch.valid <= 1'b0;
    endtask

    task automatic random_request(int max_src);
        int pick;
        logic [3:0] src;
        pick = $urandom_range(0, 9);
        src = 4'($urandom_range(0, max_src));
        if (pick < 4) send_request(tsm_pkg::K_PUSH, src, rand_time());
        else if (pick == 4) send_request(tsm_pkg::K_BOUND, 4'($urandom), rand_time());
        else if (pick < 8) send_request(tsm_pkg::K_POP_E, src, rand_time());
        else send_request(tsm_pkg::K_POP_S, src, rand_time());
    endtask

    // Write configuration only when idle (block won't check): drain first.
    task automatic write_register(logic [0:0] idx, logic [4:0] value);
        release_request();
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Receiver stalls: after a response is taken, ready may go low at random
    // before the next one, and stays high for about two responses in five.
    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
                if (stall != 0) begin
                    rsp_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            rsp_ch.ready <= 1'b1;
        end
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: every kind, the own source, empty-queue pops,
        // a limit below the head, and ties between heads.
        send_request(tsm_pkg::K_POP_E, 4'd0, '1);
        send_request(tsm_pkg::K_PUSH, 4'd0, 64'd5);
        send_request(tsm_pkg::K_PUSH, 4'd3, 64'd7);
        send_request(tsm_pkg::K_PUSH, 4'd15, 64'd7);
        send_request(tsm_pkg::K_PUSH, 4'd2, '1);
        send_request(tsm_pkg::K_PUSH, 4'd1, '0);
        send_request(tsm_pkg::K_BOUND, 4'd0, 64'd1);
        send_request(tsm_pkg::K_BOUND, 4'd15, '1);
        send_request(tsm_pkg::K_POP_S, 4'd3, 64'd6);
        send_request(tsm_pkg::K_POP_S, 4'd0, '1);
        send_request(tsm_pkg::K_POP_S, 4'd9, '1);
        send_request(tsm_pkg::K_POP_E, 4'd0, '0);
        send_request(tsm_pkg::K_POP_E, 4'd0, 64'd7);
        send_request(tsm_pkg::K_POP_E, 4'd0, 64'd7);
        send_request(tsm_pkg::K_POP_E, 4'd0, '1);
        send_request(tsm_pkg::K_POP_E, 4'd0, '1);
        // Fill one queue past its depth so the full case drops.
        for (int i = 0; i < tsm_pkg::QUEUE_DEPTH + 2; i++)
            send_request(tsm_pkg::K_PUSH, 4'd4, 64'(i));

        // Hold off until everything issued so far has been answered.
        release_request();
        while (pending != 0) @(posedge i_clk);

        write_register(tsm_pkg::REG_SELF_INDEX, 5'd15);
        write_register(tsm_pkg::REG_SOURCE_COUNT, 5'd4);
        for (int i = 0; i < 200; i++) random_request(5);
        write_register(tsm_pkg::REG_SELF_INDEX, 5'd2);
        write_register(tsm_pkg::REG_SOURCE_COUNT, 5'd0);
        for (int i = 0; i < 60; i++) random_request(15);
        write_register(tsm_pkg::REG_SOURCE_COUNT, 5'd1);
        write_register(tsm_pkg::REG_SELF_INDEX, 5'd0);
        for (int i = 0; i < 60; i++) random_request(3);
        write_register(tsm_pkg::REG_SELF_INDEX, 5'd6);
        write_register(tsm_pkg::REG_SOURCE_COUNT, 5'd31);
        for (int i = 0; i < 200; i++) random_request(15);
        write_register(tsm_pkg::REG_SELF_INDEX, 5'd4);
        write_register(tsm_pkg::REG_SOURCE_COUNT, 5'd16);
        for (int i = 0; i < 200; i++) random_request(15);

        release_request();
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("tb: failure");
        $finish;
    end
endmodule
